// ===== hw/rtl/bleadv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_pkg: shared types and codes of the advertiser table
// Opcodes, outcome codes, parser phases, report modes, FSM states, AD name types and the cell write command.
// ----------------------------------------------------------------------------
package bleadv_pkg;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		OUT_UPDATED = 3'd0,
		OUT_ADDED   = 3'd1,
		OUT_DROPPED = 3'd2,
		OUT_READ    = 3'd3,
		OUT_RANGE   = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_NAME = 3'd3,
		PH_SKIP = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_UPDATED = 2'd1,
		MODE_ADDED   = 2'd2,
		MODE_DROPPED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	localparam logic [7:0] AD_SHORT_NAME = 8'h08;
	localparam logic [7:0] AD_FULL_NAME  = 8'h09;

	// write command broadcast to the cell row
	typedef struct packed {
		logic add;       // load address and level, drop name
		logic set_level; // replace level
		logic set_name;  // mark named, load length
	} cell_cmd_t;

endpackage

// ===== hw/rtl/bleadv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bleadv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bleadv_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_cell: one table entry
// Holds address, level and name status; compares its address with the key.
// ----------------------------------------------------------------------------
module bleadv_cell #(
	parameter int IDX = 0,
	parameter int SW  = 6,
	parameter int LW  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bleadv_pkg::cell_cmd_t cmd,
	input  logic [SW-1:0]         wr_slot,
	input  logic [47:0]           key,
	input  logic                  cmp_en,
	input  logic [7:0]            wr_level,
	input  logic [LW-1:0]         wr_len,
	input  logic [SW-1:0]         rd_slot,
	output logic                  match,
	output logic [47:0]           rd_addr,
	output logic [7:0]            rd_level,
	output logic                  rd_named,
	output logic [LW-1:0]         rd_len
);
	import bleadv_pkg::*;

	logic [47:0]   addr_q;
	logic [7:0]    level_q;
	logic          named_q;
	logic [LW-1:0] len_q;
	logic          match_q;
	logic          mine;
	logic          pick;

	assign mine = (wr_slot == SW'(IDX));
	assign pick = (rd_slot == SW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmp_en) begin
			match_q <= (addr_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (mine && cmd.add) begin
			addr_q <= key;
		end
		if (mine && (cmd.add || cmd.set_level)) begin
			level_q <= wr_level;
		end
		if (mine && cmd.set_name) begin
			named_q <= 1'b1;
			len_q   <= wr_len;
		end else if (mine && cmd.add) begin
			named_q <= 1'b0;
			len_q   <= '0;
		end
	end

	assign match    = match_q;
	// drive the shared read bus only when selected
	assign rd_addr  = pick ? addr_q  : '0;
	assign rd_level = pick ? level_q : '0;
	assign rd_named = pick & named_q;
	assign rd_len   = pick ? len_q   : '0;

endmodule

// ===== hw/rtl/ble_adv_device_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_device_table: table of discovered advertisers
// Address match across a row of entry cells, AD structure parsing, name
// capture into a byte RAM, clear and read-out of one entry.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser / tlast
// s_      | in  | device_address, signal_level, payload_length,    | tuser: opcode,
//         |     | payload_byte, read_slot, read_char               | first_byte; tlast
// m_      | out | slot_index, named, name_length, entries_used,    | tuser: outcome
//         |     | entry_address, entry_level, name_char            |
//
// Each word is handled in an accept step (cells compare the address, name RAM
// read issued), then an execute step (table and parser update, result registered).
// A result that cannot leave the output register holds the block in execute.
// Reset clears the count and the parser; entry contents and name RAM need
// no reset, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ble_adv_device_table #(
	parameter int MAX_ENTRIES   = 64,
	parameter int NAME_CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // device_address, signal_level, payload_length,
	                              // payload_byte, read_slot, read_char, zero fill
	input  logic [2:0]  s_tuser,  // opcode, first_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // slot_index, named, name_length, entries_used,
	                              // entry_address, entry_level, name_char, zero fill
	output logic [2:0]  m_tuser   // outcome
);
	import bleadv_pkg::*;

	localparam int SW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int NCM1  = NAME_CAPACITY - 1;
	localparam int LW    = $clog2(NAME_CAPACITY);
	localparam int DEPTH = MAX_ENTRIES * NCM1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t         st_q;
	logic [1:0]     op_q;
	logic [47:0]    addr_q;
	logic [7:0]     lvl_q;
	logic [7:0]     plen_q;
	logic [7:0]     pb_q;
	logic           first_q;
	logic           last_q;
	logic [5:0]     rslot_q;
	logic [4:0]     rchar_q;

	logic [CW-1:0]  count_q, n_count;
	logic [7:0]     pos_q, n_pos;
	logic [7:0]     se_q, n_se;
	phase_t         ph_q, n_ph;
	logic [SW-1:0]  slot_q, n_slot;
	mode_t          mode_q, n_mode;
	logic [LW-1:0]  wlen_q, n_wlen;

	logic           accept;
	logic           go;
	logic           need_out;
	cell_cmd_t      cmd;
	cell_cmd_t      cmd_go;
	logic [LW-1:0]  cmd_len;
	logic [SW-1:0]  sel;
	logic           commit;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] hit;
	logic [47:0]    c_addr [MAX_ENTRIES];
	logic [7:0]     c_level [MAX_ENTRIES];
	logic           c_named [MAX_ENTRIES];
	logic [LW-1:0]  c_len [MAX_ENTRIES];
	logic [47:0]    b_addr;
	logic [7:0]     b_level;
	logic           b_named;
	logic [LW-1:0]  b_len;
	logic           any_hit;
	logic [SW-1:0]  hit_slot;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_q;

	logic [5:0]     r_slot;
	outcome_t       r_outcome;
	logic           r_named;
	logic [LW-1:0]  r_len;
	logic [47:0]    r_addr;
	logic [7:0]     r_level;
	logic [7:0]     r_char;

	logic           out_valid_q;
	logic [87:0]    out_data_q;
	logic [2:0]     out_user_q;

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser[1:0];
			first_q <= s_tuser[2];
			last_q  <= s_tlast;
			addr_q  <= s_tdata[47:0];
			lvl_q   <= s_tdata[55:48];
			plen_q  <= s_tdata[63:56];
			pb_q    <= s_tdata[71:64];
			rslot_q <= s_tdata[77:72];
			rchar_q <= s_tdata[82:78];
		end
	end

	// write the cells only on the cycle the word completes
	assign cmd_go = go ? cmd : '0;

	// entry row
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		bleadv_cell #(.IDX(i), .SW(SW), .LW(LW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_go),
			.wr_slot (n_slot),
			.key     (accept ? s_tdata[47:0] : addr_q),
			.cmp_en  (accept),
			.wr_level(lvl_q),
			.wr_len  (cmd_len),
			.rd_slot (sel),
			.match   (match[i]),
			.rd_addr (c_addr[i]),
			.rd_level(c_level[i]),
			.rd_named(c_named[i]),
			.rd_len  (c_len[i])
		);
		assign hit[i] = match[i] && (CW'(i) < count_q);
	end

	always_comb begin
		any_hit  = 1'b0;
		hit_slot = '0;
		b_addr   = '0;
		b_level  = '0;
		b_named  = 1'b0;
		b_len    = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			any_hit  = any_hit | hit[i];
			hit_slot = hit_slot | (hit[i] ? SW'(i) : '0);
			b_addr   = b_addr | c_addr[i];
			b_level  = b_level | c_level[i];
			b_named  = b_named | c_named[i];
			b_len    = b_len | c_len[i];
		end
	end

	always_comb begin
		if (op_q == OP_READ) begin
			sel = SW'(rslot_q);
		end else if (first_q && any_hit) begin
			sel = hit_slot;
		end else begin
			sel = slot_q;
		end
	end

	bleadv_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_name_ram (
		.clk  (clk),
		.we   (ram_we && go),
		.waddr(ram_waddr),
		.wdata(pb_q),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_q)
	);

	assign ram_raddr = AW'(s_tdata[77:72]) * AW'(NCM1) + AW'(s_tdata[82:78]);
	assign ram_waddr = AW'(n_slot) * AW'(NCM1) + AW'(wlen_q);

	always_comb begin
		n_count   = count_q;
		n_pos     = pos_q;
		n_se      = se_q;
		n_ph      = ph_q;
		n_slot    = slot_q;
		n_mode    = mode_q;
		n_wlen    = wlen_q;
		cmd       = '0;
		cmd_len   = wlen_q;
		commit    = 1'b0;
		ram_we    = 1'b0;
		need_out  = 1'b0;
		r_slot    = '0;
		r_outcome = OUT_UPDATED;
		r_named   = 1'b0;
		r_len     = '0;
		r_addr    = '0;
		r_level   = '0;
		r_char    = '0;
		unique case (op_q)
			OP_CLEAR: begin
				n_count = '0;
				n_pos   = '0;
				n_se    = '0;
				n_ph    = PH_IDLE;
				n_slot  = '0;
				n_mode  = MODE_NONE;
			end
			OP_READ: begin
				need_out = 1'b1;
				r_slot   = rslot_q;
				if ({3'b0, rslot_q} < 9'(count_q)) begin
					r_outcome = OUT_READ;
					r_named   = b_named;
					r_len     = b_named ? b_len : '0;
					r_addr    = b_addr;
					r_level   = b_level;
					if (b_named && (LW'(rchar_q) < b_len) && ({3'b0, rchar_q} < 8'(NCM1))) begin
						r_char = ram_q;
					end
				end else begin
					r_outcome = OUT_RANGE;
				end
			end
			OP_REPORT: begin
				if (first_q) begin
					n_pos = '0;
					n_se  = '0;
					if (any_hit) begin
						n_slot        = hit_slot;
						n_mode        = MODE_UPDATED;
						n_ph          = b_named ? PH_IDLE : PH_LEN;
						cmd.set_level = 1'b1;
					end else if (count_q < CW'(MAX_ENTRIES)) begin
						n_slot  = SW'(count_q);
						n_count = count_q + 1'b1;
						n_mode  = MODE_ADDED;
						n_ph    = PH_LEN;
						cmd.add = 1'b1;
					end else begin
						n_slot = '0;
						n_mode = MODE_DROPPED;
						n_ph   = PH_IDLE;
					end
				end
				if (n_mode != MODE_NONE) begin
					if (n_pos < plen_q) begin
						unique case (n_ph)
							PH_LEN: begin
								if ((pb_q == 8'd0) ||
								    ({1'b0, n_pos} + {1'b0, pb_q} >= {1'b0, plen_q})) begin
									n_ph = PH_DONE;
								end else begin
									n_se = n_pos + pb_q;
									n_ph = PH_TYPE;
								end
							end
							PH_TYPE: begin
								if ((pb_q == AD_SHORT_NAME) || (pb_q == AD_FULL_NAME)) begin
									n_wlen = '0;
									if (n_pos == n_se) begin
										commit  = 1'b1;
										cmd_len = '0;
										n_ph    = PH_DONE;
									end else begin
										n_ph = PH_NAME;
									end
								end else begin
									n_ph = (n_pos == n_se) ? PH_LEN : PH_SKIP;
								end
							end
							PH_NAME: begin
								if (wlen_q < LW'(NCM1)) begin
									ram_we = 1'b1;
									n_wlen = wlen_q + 1'b1;
								end
								if (n_pos == n_se) begin
									commit  = 1'b1;
									cmd_len = n_wlen;
									n_ph    = PH_DONE;
								end
							end
							PH_SKIP: begin
								if (n_pos == n_se) begin
									n_ph = PH_LEN;
								end
							end
							default: begin
							end
						endcase
					end
					cmd.set_name = commit;
					if (n_pos != 8'hFF) begin
						n_pos = n_pos + 1'b1;
					end
					if (last_q) begin
						need_out = 1'b1;
						if (n_mode == MODE_DROPPED) begin
							r_outcome = OUT_DROPPED;
						end else begin
							r_slot    = 6'(n_slot);
							r_outcome = (n_mode == MODE_ADDED) ? OUT_ADDED : OUT_UPDATED;
							if (commit) begin
								r_named = 1'b1;
								r_len   = cmd_len;
							end else if (first_q && (n_mode == MODE_ADDED)) begin
								r_named = 1'b0;
							end else begin
								r_named = b_named;
								r_len   = b_named ? b_len : '0;
							end
							r_addr  = first_q ? addr_q : b_addr;
							r_level = first_q ? lvl_q : b_level;
						end
						n_mode = MODE_NONE;
						n_ph   = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign go = (st_q == ST_EXEC) && (!need_out || !out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			se_q        <= '0;
			ph_q        <= PH_IDLE;
			slot_q      <= '0;
			mode_q      <= MODE_NONE;
			wlen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go && need_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						st_q    <= ST_IDLE;
						count_q <= n_count;
						pos_q   <= n_pos;
						se_q    <= n_se;
						ph_q    <= n_ph;
						slot_q  <= n_slot;
						mode_q  <= n_mode;
						wlen_q  <= n_wlen;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && need_out) begin
			out_user_q <= r_outcome;
			out_data_q <= {5'b0, r_char, r_level, r_addr, 7'(count_q == n_count ? count_q : n_count),
			               5'(r_len), r_named, r_slot};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXEC) |-> $onehot0(hit))
		else $error("address held by more than one entry");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(go && need_out) |=> out_valid_q)
		else $error("result not loaded into output register");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !(ram_we && go))
		else $error("name write outside execute");

endmodule

// ===== bench/ble_adv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_checker: predictor and scoreboard of the advertiser table
// Watches both stream channels, keeps its own copy of the table and the AD
// parser, queues the expected result words and compares them field by field.
// ----------------------------------------------------------------------------
module ble_adv_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	import bleadv_pkg::*;

	localparam int ENTRIES  = 64;
	localparam int NAME_MAX = 31;

	typedef struct packed {
		logic [5:0]  slot;
		outcome_t    outcome;
		logic        named;
		logic [4:0]  text_len;
		logic [6:0]  used;
		logic [47:0] addr;
		logic [7:0]  level;
		logic [7:0]  name_char;
	} table_result_t;

	logic [47:0] addr_mem [ENTRIES];
	logic [7:0]  level_mem [ENTRIES];
	logic        named_mem [ENTRIES];
	logic [4:0]  nlen_mem [ENTRIES];
	logic [7:0]  name_mem [ENTRIES][NAME_MAX];
	int          entry_cnt;
	int          pos;
	int          struct_end;
	phase_t      phase;
	int          cur_slot;
	mode_t       mode;

	table_result_t expected_words[$];

	assign pending = expected_words.size();

	function automatic void walk_ad_byte(input logic [7:0] b, input int total);
		if (pos >= total)
			return;
		case (phase)
			PH_LEN: begin
				if (b == 0 || pos + int'(b) >= total) begin
					phase = PH_DONE;
				end else begin
					struct_end = pos + int'(b);
					phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b == AD_SHORT_NAME || b == AD_FULL_NAME) begin
					nlen_mem[cur_slot] = 5'd0;
					if (pos == struct_end) begin
						named_mem[cur_slot] = 1'b1;
						phase = PH_DONE;
					end else begin
						phase = PH_NAME;
					end
				end else begin
					phase = (pos == struct_end) ? PH_LEN : PH_SKIP;
				end
			end
			PH_NAME: begin
				if (nlen_mem[cur_slot] < NAME_MAX) begin
					name_mem[cur_slot][nlen_mem[cur_slot]] = b;
					nlen_mem[cur_slot]++;
				end
				if (pos == struct_end) begin
					named_mem[cur_slot] = 1'b1;
					phase = PH_DONE;
				end
			end
			PH_SKIP: begin
				if (pos == struct_end)
					phase = PH_LEN;
			end
			default: ;
		endcase
	endfunction

	function automatic void open_report(input logic [47:0] a, input logic [7:0] lvl);
		pos = 0;
		struct_end = 0;
		for (int i = 0; i < entry_cnt; i++) begin
			if (addr_mem[i] == a) begin
				level_mem[i] = lvl;
				cur_slot = i;
				mode = MODE_UPDATED;
				phase = named_mem[i] ? PH_IDLE : PH_LEN;
				return;
			end
		end
		if (entry_cnt < ENTRIES) begin
			addr_mem[entry_cnt] = a;
			level_mem[entry_cnt] = lvl;
			named_mem[entry_cnt] = 1'b0;
			nlen_mem[entry_cnt] = 5'd0;
			cur_slot = entry_cnt;
			entry_cnt++;
			mode = MODE_ADDED;
			phase = PH_LEN;
		end else begin
			cur_slot = 0;
			mode = MODE_DROPPED;
			phase = PH_IDLE;
		end
	endfunction

	// advance the table by one accepted word, queue its result if any
	function automatic void apply_word(input logic [87:0] d, input logic [2:0] u,
	                                   input logic last);
		opcode_t       op;
		int            rslot;
		int            rchar;
		table_result_t r;
		op = opcode_t'(u[1:0]);
		rslot = int'(d[77:72]);
		rchar = int'(d[82:78]);
		r = '0;
		r.outcome = OUT_UPDATED;
		case (op)
			OP_CLEAR: begin
				entry_cnt = 0;
				pos = 0;
				struct_end = 0;
				phase = PH_IDLE;
				cur_slot = 0;
				mode = MODE_NONE;
			end
			OP_READ: begin
				r.used = 7'(entry_cnt);
				r.slot = 6'(rslot);
				if (rslot < entry_cnt) begin
					r.outcome = OUT_READ;
					r.named = named_mem[rslot];
					r.text_len = named_mem[rslot] ? nlen_mem[rslot] : 5'd0;
					r.addr = addr_mem[rslot];
					r.level = level_mem[rslot];
					if (named_mem[rslot] && rchar < int'(nlen_mem[rslot]))
						r.name_char = name_mem[rslot][rchar];
				end else begin
					r.outcome = OUT_RANGE;
				end
				expected_words.push_back(r);
			end
			OP_REPORT: begin
				if (u[2])
					open_report(d[47:0], d[55:48]);
				if (mode != MODE_NONE) begin
					walk_ad_byte(d[71:64], int'(d[63:56]));
					if (pos < 255)
						pos++;
					if (last) begin
						r.used = 7'(entry_cnt);
						if (mode == MODE_DROPPED) begin
							r.outcome = OUT_DROPPED;
						end else begin
							r.slot = 6'(cur_slot);
							r.outcome = (mode == MODE_ADDED) ? OUT_ADDED : OUT_UPDATED;
							r.named = named_mem[cur_slot];
							r.text_len = named_mem[cur_slot] ? nlen_mem[cur_slot] : 5'd0;
							r.addr = addr_mem[cur_slot];
							r.level = level_mem[cur_slot];
						end
						expected_words.push_back(r);
						mode = MODE_NONE;
						phase = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t got;
		table_result_t exp_w;
		if (!arst_n) begin
			entry_cnt = 0;
			pos = 0;
			struct_end = 0;
			phase = PH_IDLE;
			cur_slot = 0;
			mode = MODE_NONE;
			expected_words.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.slot = m_tdata[5:0];
				got.outcome = outcome_t'(m_tuser);
				got.named = m_tdata[6];
				got.text_len = m_tdata[11:7];
				got.used = m_tdata[18:12];
				got.addr = m_tdata[66:19];
				got.level = m_tdata[74:67];
				got.name_char = m_tdata[82:75];
				results_seen++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word: %p", got);
					fail_count++;
				end else begin
					exp_w = expected_words.pop_front();
					if (got.slot !== exp_w.slot) begin
						$error("slot_index: expected %0d, got %0d", exp_w.slot, got.slot);
						fail_count++;
					end
					if (got.outcome !== exp_w.outcome) begin
						$error("outcome: expected %0d, got %0d", exp_w.outcome, got.outcome);
						fail_count++;
					end
					if (got.named !== exp_w.named) begin
						$error("named: expected %0d, got %0d", exp_w.named, got.named);
						fail_count++;
					end
					if (got.text_len !== exp_w.text_len) begin
						$error("name_length: expected %0d, got %0d",
							exp_w.text_len, got.text_len);
						fail_count++;
					end
					if (got.used !== exp_w.used) begin
						$error("entries_used: expected %0d, got %0d", exp_w.used, got.used);
						fail_count++;
					end
					if (got.addr !== exp_w.addr) begin
						$error("entry_address: expected %h, got %h", exp_w.addr, got.addr);
						fail_count++;
					end
					if (got.level !== exp_w.level) begin
						$error("entry_level: expected %0d, got %0d",
							$signed(exp_w.level), $signed(got.level));
						fail_count++;
					end
					if (got.name_char !== exp_w.name_char) begin
						$error("name_char: expected %h, got %h",
							exp_w.name_char, got.name_char);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_word(s_tdata, s_tuser, s_tlast);
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the advertiser table
// Directed reports, reads and clears, then random report streams built from
// well-formed AD structures with noise, under three idling regimes.
// ----------------------------------------------------------------------------
module tb_top;
	import bleadv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [2:0]  m_tuser;

	int fail_count;
	int pending;
	int results_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_sent = 0;
	int reports_sent = 0;
	int stall_cycles = 0;
	logic [47:0] addr_pool [24];

	always #1 clk = ~clk;

	ble_adv_device_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	ble_adv_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// drive one word, hold it until accepted
	task automatic send_word(input opcode_t op, input logic [47:0] a, input logic [7:0] lvl,
	                         input logic [7:0] plen, input logic [7:0] pb,
	                         input logic first, input logic last,
	                         input logic [5:0] rslot, input logic [4:0] rchar);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {5'd0, rchar, rslot, pb, plen, lvl, a};
		s_tuser <= {first, op};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		// tready only moves at the rising edge, so it is stable here
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic send_noise(input opcode_t op, input logic first);
		send_word(op, 48'({$urandom, $urandom}), 8'($urandom), 8'($urandom), 8'($urandom),
			first, 1'($urandom), 6'($urandom), 5'($urandom));
	endtask

	task automatic read_entry(input logic [5:0] slot, input logic [4:0] ch);
		send_word(OP_READ, 48'({$urandom, $urandom}), 8'($urandom), 8'($urandom),
			8'($urandom), 1'($urandom), 1'($urandom), slot, ch);
	endtask

	// stream a report: item k carries data[k]; nitems may cut it short or run past
	task automatic stream_report(input logic [47:0] a, input logic [7:0] lvl,
	                             input logic [7:0] data[$], input logic [7:0] plen,
	                             input int nitems, input bit close);
		logic [7:0] b;
		for (int k = 0; k < nitems; k++) begin
			b = (k < data.size()) ? data[k] : 8'($urandom);
			send_word(OP_REPORT, (k == 0) ? a : 48'($urandom), (k == 0) ? lvl : 8'($urandom),
				plen, b, k == 0, close && (k == nitems - 1), 6'($urandom), 5'($urandom));
		end
		reports_sent++;
	endtask

	// AD payload: up to two other structures, then an optional name structure of random length, sometimes a stray byte
	function automatic void build_payload(ref logic [7:0] data[$], input bit with_name,
	                                      input int nbytes);
		int n;
		data.delete();
		n = $urandom_range(0, 2);
		for (int s = 0; s < n; s++) begin
			int len;
			len = $urandom_range(1, 4);
			data.push_back(8'(len));
			data.push_back($urandom_range(0, 1) ? 8'h01 : 8'hFF);
			for (int i = 1; i < len; i++)
				data.push_back(8'($urandom));
		end
		if (with_name) begin
			data.push_back(8'(nbytes + 1));
			data.push_back($urandom_range(0, 1) ? AD_SHORT_NAME : AD_FULL_NAME);
			for (int i = 0; i < nbytes; i++)
				data.push_back(8'($urandom_range(32, 255)));
		end
		if ($urandom_range(0, 3) == 0)
			data.push_back(8'($urandom));
	endfunction

	task automatic random_report();
		logic [7:0] data[$];
		logic [47:0] a;
		int plen;
		int nitems;
		int pick;
		a = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom}) :
			addr_pool[$urandom_range(0, 23)];
		build_payload(data, $urandom_range(0, 9) < 8, $urandom_range(0, 36));
		if (data.size() > 0 && $urandom_range(0, 9) == 0)
			data[$urandom_range(0, data.size() - 1)] = 8'($urandom);
		plen = data.size();
		nitems = plen;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			plen = plen - $urandom_range(0, plen);
		else if (pick == 1)
			nitems = $urandom_range(1, plen);
		else if (pick == 2)
			nitems = plen + $urandom_range(1, 3);
		else if (pick == 3)
			plen = 0;
		if (plen > 255)
			plen = 255;
		if (nitems < 1)
			nitems = 1;
		if (nitems > 60 && pick != 2)
			nitems = (plen > 0) ? plen : 1;
		// abandon now and then: no last byte, the next report takes over
		stream_report(a, 8'($urandom), data, 8'(plen), nitems, $urandom_range(0, 19) != 0);
	endtask

	task automatic run_random(input int count);
		int start;
		int pick;
		start = words_sent;
		while (words_sent - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				random_report();
			else if (pick < 88)
				read_entry(6'($urandom_range(0, 63)), 5'($urandom_range(0, 30)));
			else if (pick < 91)
				send_noise(OP_CLEAR, 1'($urandom));
			else if (pick < 95)
				send_noise(OP_NONE, 1'($urandom));
			else
				send_noise(OP_REPORT, 1'b0);
		end
	endtask

	// fill the table with one-word reports, then overflow it
	task automatic fill_table();
		logic [7:0] none[$];
		for (int i = 0; i < 66; i++)
			stream_report({16'hF00D, 32'(i)}, 8'($urandom), none, 8'd0, 1, 1'b1);
		read_entry(6'd63, 5'($urandom_range(0, 30)));
	endtask

	initial begin
		logic [7:0] data[$];
		for (int i = 0; i < 24; i++)
			addr_pool[i] = 48'({$urandom, $urandom});
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 70;
		// directed part
		read_entry(6'd0, 5'd0);
		build_payload(data, 1, 5);
		stream_report('1, 8'h80, data, 8'(data.size()), data.size(), 1'b1);
		read_entry(6'd0, 5'd0);
		stream_report('1, 8'h7F, data, 8'(data.size()), data.size(), 1'b1);
		data = '{8'h00, 8'h09, 8'h41};
		stream_report('0, 8'h00, data, 8'd255, 3, 1'b1);
		data = '{8'h05, 8'h09, 8'h41};
		stream_report(48'h1, 8'h10, data, 8'd3, 3, 1'b1);
		send_word(OP_REPORT, '0, '0, 8'd3, 8'h01, 1'b0, 1'b1, '0, '0);
		send_word(OP_NONE, '1, '1, '1, '1, 1'b1, 1'b1, '1, '1);
		data = '{8'h01, 8'h08};
		stream_report(48'h2, 8'h20, data, 8'd2, 2, 1'b0);
		data = '{8'h02, 8'h09, 8'hFF};
		stream_report(48'h3, 8'hF0, data, 8'd3, 3, 1'b1);
		read_entry(6'd31, 5'd30);
		read_entry(6'd63, 5'd31);
		send_word(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
		read_entry(6'd0, 5'd0);

		run_random(100);
		fill_table();
		// hold off until the table has answered everything
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		run_random(100);

		send_idle_pct = 70;
		recv_idle_pct = 34;
		run_random(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(200);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		$display("Sent %0d words in %0d reports plus reads, clears and stray words;",
			words_sent, reports_sent);
		$display("checked %0d result words, including a full-table overflow.", results_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
